[rtl/kcf_pkg.sv]
// ----------------------------------------------------------------------------
// kcf_pkg - shared types and constants for the keyframe change filter
// Frame geometry, field widths, payload structs and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package kcf_pkg;

	// Frame geometry
	localparam int THUMB_SIDE   = 64;
	localparam int FRAME_PIXELS = THUMB_SIDE * THUMB_SIDE;
	localparam int IDX_W        = $clog2(FRAME_PIXELS);

	// Field widths
	localparam int PIXEL_W = 8;
	localparam int SUM_W   = 20;
	localparam int CFG_W   = 12;

	// Threshold compare width: 16 * sum against min_diff_q4 * FRAME_PIXELS
	localparam int RHS_W = CFG_W + $clog2(FRAME_PIXELS + 1);
	localparam int LHS_W = SUM_W + 4;
	localparam int CMP_W = (RHS_W > LHS_W) ? RHS_W : LHS_W;

	// Register reset value (12.0 in 8.4 fixed point)
	localparam int MIN_DIFF_RESET = 192;

	// Decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_PIXELS - 1);
	localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               group_start;
	} in_t;

	typedef struct packed {
		logic             keep;
		logic             first_of_group;
		logic [SUM_W-1:0] difference_sum;
	} out_t;

	// Classified pixel handed from front to back
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [IDX_W-1:0]   idx;
		logic               first;
		logic               last;
	} item_t;

endpackage

`default_nettype wire

[rtl/keyframe_change_filter_core.sv]
// ----------------------------------------------------------------------------
// keyframe_change_filter_core - near-duplicate frame rejection
// Top level: intake front, decoupling queue and difference back end.
// ----------------------------------------------------------------------------
// Pixels of a THUMB_SIDE x THUMB_SIDE grayscale thumbnail arrive in raster
// order, one transaction per pixel, and one pixel is taken every clock while
// the four-entry queue has room; the back end drains one pixel per clock
// unless a last pixel waits, set by its single pass through the bank read
// ports and the accumulate-and-compare path. One result transaction follows
// the last pixel of a frame, through the queue, the back-end stage register
// and the result register. It carries keep, first_of_group and the sum of
// absolute differences against the last kept frame. The last pixel waits in
// the back end only while a previous result is still unread. The banks need
// no clearing after reset; the first frame after reset is always kept.
// min_diff_q4 may only be written while no frame is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_change_filter_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire kcf_pkg::in_t                in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output kcf_pkg::out_t                    out_data,
	input  wire logic                        cfg_we,
	input  wire logic [kcf_pkg::CFG_W-1:0]   cfg_wdata
);
	import kcf_pkg::*;

	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_valid;
	logic  q_full;
	item_t q_item;

	// Classify incoming pixels
	kcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Decouple intake from processing
	kcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.q_item    (q_item)
	);

	// Accumulate, decide and report
	kcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[rtl/kcf_front.sv]
// ----------------------------------------------------------------------------
// kcf_front - pixel intake and classification
// Tracks the position within the frame, decides whether the frame is the
// first of a group and tags each pixel before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kcf_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire kcf_pkg::in_t  in_data,
	input  wire logic          q_full,
	output logic               push,
	output kcf_pkg::item_t     push_item
);
	import kcf_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             have_ref_q;
	logic             first_q;
	logic             first_now;
	logic             is_last;

	// Stall whenever the queue has no room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Sample the group flag on the first pixel of a frame only
	assign first_now = (idx_q == '0) ? (in_data.group_start || !have_ref_q) : first_q;
	assign is_last   = (idx_q == LAST_IDX);

	assign push_item.pixel = in_data.pixel;
	assign push_item.idx   = idx_q;
	assign push_item.first = first_now;
	assign push_item.last  = is_last;

	// Advance frame position and group state per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			have_ref_q <= 1'b0;
			first_q    <= 1'b0;
		end else if (push) begin
			first_q <= first_now;
			if (is_last) begin
				idx_q <= '0;
				if (first_now) begin
					have_ref_q <= 1'b1;
				end
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/kcf_queue.sv]
// ----------------------------------------------------------------------------
// kcf_queue - short queue between front and back
// Register-based FIFO so that intake and processing stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module kcf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire kcf_pkg::item_t push_item,
	input  wire logic           pop,
	output logic                q_valid,
	output logic                q_full,
	output kcf_pkg::item_t      q_item
);
	import kcf_pkg::*;

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_item  = slot_q[rd_ptr_q];

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[rtl/kcf_back.sv]
// ----------------------------------------------------------------------------
// kcf_back - difference accumulation and keep decision
// Holds the two thumbnail banks, sums absolute differences against the
// reference bank, decides keep or drop at frame end and swaps banks on keep.
// ----------------------------------------------------------------------------
`default_nettype none

module kcf_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire kcf_pkg::item_t              q_item,
	output logic                             pop,
	input  wire logic                        cfg_we,
	input  wire logic [kcf_pkg::CFG_W-1:0]   cfg_wdata,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output kcf_pkg::out_t                    out_data
);
	import kcf_pkg::*;

	// Thumbnail banks
	logic [PIXEL_W-1:0] bank0_q [FRAME_PIXELS];
	logic [PIXEL_W-1:0] bank1_q [FRAME_PIXELS];

	logic               valid_s1;
	item_t              item_s1;
	logic [PIXEL_W-1:0] rd0_s1;
	logic [PIXEL_W-1:0] rd1_s1;

	logic               ref_bank_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CMP_W-1:0]   rhs_q;
	logic               out_valid_q;
	out_t               out_data_q;

	logic               advance;
	logic               s1_fire;
	logic [PIXEL_W-1:0] ref_px;
	logic [PIXEL_W-1:0] diff;
	logic [SUM_W-1:0]   base;
	logic [SUM_W:0]     wide_sum;
	logic [SUM_W-1:0]   sat_sum;
	logic [SUM_W-1:0]   sum_next;
	logic [CMP_W-1:0]   lhs;
	logic               keep;

	// Hold the last pixel of a frame while an earlier result is unread
	assign advance = !valid_s1 || !(item_s1.last && out_valid_q && out_stall);
	assign pop     = q_valid && advance;
	assign s1_fire = valid_s1 && advance;

	// Pick the reference pixel and form the absolute difference
	assign ref_px = ref_bank_q ? rd1_s1 : rd0_s1;
	assign diff   = (item_s1.pixel > ref_px) ? (item_s1.pixel - ref_px)
	                                         : (ref_px - item_s1.pixel);

	// Accumulate with saturation; the sum restarts on the first pixel
	assign base     = (item_s1.idx == '0) ? '0 : sum_q;
	assign wide_sum = {1'b0, base} + {{(SUM_W + 1 - PIXEL_W){1'b0}}, diff};
	assign sat_sum  = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
	assign sum_next = item_s1.first ? '0 : sat_sum;

	// Drop when 16 * sum is below threshold * frame size, unless first of group
	assign lhs  = CMP_W'({sum_next, 4'b0000});
	assign keep = item_s1.first || !(lhs < rhs_q);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control state, threshold and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ref_bank_q  <= 1'b0;
			sum_q       <= '0;
			rhs_q       <= CMP_W'(MIN_DIFF_RESET) * CMP_W'(FRAME_PIXELS);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rhs_q <= CMP_W'(cfg_wdata) * CMP_W'(FRAME_PIXELS);
			end
			if (advance) begin
				valid_s1 <= pop;
			end
			if (s1_fire) begin
				sum_q <= sum_next;
			end
			if (s1_fire && item_s1.last) begin
				out_valid_q <= 1'b1;
				if (keep) begin
					ref_bank_q <= !ref_bank_q;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage payload, bank reads and bank writes
	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= q_item;
			rd0_s1  <= bank0_q[q_item.idx];
			rd1_s1  <= bank1_q[q_item.idx];
		end
		if (s1_fire) begin
			if (ref_bank_q) begin
				bank0_q[item_s1.idx] <= item_s1.pixel;
			end else begin
				bank1_q[item_s1.idx] <= item_s1.pixel;
			end
		end
		if (s1_fire && item_s1.last) begin
			out_data_q.keep           <= keep;
			out_data_q.first_of_group <= item_s1.first;
			out_data_q.difference_sum <= sum_next;
		end
	end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for keyframe_change_filter_core
// Streams whole thumbnail frames through the core and predicts the keep/drop
// decision of each frame from a local model of both pixel banks. Results are
// checked in order against the prediction. Directed frames cover first-frame
// rules, extreme sums and the exact threshold boundary. Random frames follow
// under several thresholds, idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;

	import kcf_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLDOFF_CYCLES = 12000;

	typedef enum int {
		FRAME_FLAT,
		FRAME_NEAR,
		FRAME_NOISE
	} frame_kind_e;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// Idle rates in percent, stall hold-off counter
	int src_idle_pct = 9;
	int snk_idle_pct = 74;
	int stall_hold = 0;
	int mismatches = 0;

	// Model of the core state
	logic [PIXEL_W-1:0] thumb_store [2][FRAME_PIXELS];
	bit                 ref_sel = 1'b0;
	bit                 have_ref = 1'b0;
	int unsigned        px_idx = 0;
	int unsigned        acc_sum = 0;
	bit                 cur_first = 1'b0;
	logic [CFG_W-1:0]   thresh_q4 = CFG_W'(MIN_DIFF_RESET);
	out_t               frame_results [$];

	keyframe_change_filter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the model by one accepted pixel; queue a result at frame end
	function automatic void step_frame_model(input in_t d);
		logic [PIXEL_W-1:0] old;
		int unsigned        diff;
		longint unsigned    lhs;
		longint unsigned    rhs;
		out_t               res;
		if (px_idx == 0) begin
			cur_first = d.group_start || !have_ref;
			acc_sum = 0;
		end
		if (!cur_first) begin
			old = thumb_store[ref_sel][px_idx];
			diff = (d.pixel > old) ? int'(d.pixel - old) : int'(old - d.pixel);
			acc_sum = acc_sum + diff;
			if (acc_sum > int'(SUM_MAX))
				acc_sum = int'(SUM_MAX);
		end
		thumb_store[~ref_sel][px_idx] = d.pixel;
		if (px_idx != FRAME_PIXELS - 1) begin
			px_idx++;
			return;
		end
		px_idx = 0;
		if (cur_first) begin
			res.keep = 1'b1;
			res.first_of_group = 1'b1;
			res.difference_sum = '0;
			ref_sel = ~ref_sel;
			have_ref = 1'b1;
		end else begin
			lhs = longint'(acc_sum) * 16;
			rhs = longint'(thresh_q4) * FRAME_PIXELS;
			res.keep = !(lhs < rhs);
			res.first_of_group = 1'b0;
			res.difference_sum = acc_sum[SUM_W-1:0];
			if (res.keep)
				ref_sel = ~ref_sel;
		end
		frame_results = {frame_results, res};
		acc_sum = 0;
		cur_first = 1'b0;
	endfunction

	// Offer one pixel, hold it until the core takes it
	task automatic send_pixel(input in_t d);
		bit taken;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		step_frame_model(d);
	endtask

	// Send one whole frame; mid_gs_pct sets group_start noise after pixel 0
	task automatic send_frame(input bit gs, input frame_kind_e kind, input int level,
			input int noise, input int mid_gs_pct, input int last_px);
		in_t d;
		int  v;
		for (int i = 0; i < FRAME_PIXELS; i++) begin
			case (kind)
				FRAME_FLAT: v = level;
				FRAME_NEAR: v = int'(thumb_store[ref_sel][i])
						+ int'($urandom_range(0, 2 * noise)) - noise;
				default: v = int'($urandom_range(0, 255));
			endcase
			if (i == FRAME_PIXELS - 1 && last_px >= 0)
				v = last_px;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			d.pixel = v[PIXEL_W-1:0];
			d.group_start = (i == 0) ? gs : ($urandom_range(0, 99) < mid_gs_pct);
			send_pixel(d);
		end
	endtask

	// Drop valid and wait until every result has been read
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (frame_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [CFG_W-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thresh_q4 = v;
	endtask

	// First frame after reset is kept without group_start
	task automatic test_first_after_reset();
		send_frame(1'b0, FRAME_FLAT, 0, 0, 0, -1);
	endtask

	// Largest possible sum, zero sum, and a group start on noise
	task automatic test_field_extremes();
		send_frame(1'b0, FRAME_FLAT, 255, 0, 0, -1);
		send_frame(1'b0, FRAME_FLAT, 255, 0, 0, -1);
		send_frame(1'b1, FRAME_NOISE, 0, 0, 0, -1);
	endtask

	// Sum exactly at the threshold keeps, one below drops
	task automatic test_threshold_boundary();
		send_frame(1'b1, FRAME_FLAT, 100, 0, 0, -1);
		send_frame(1'b0, FRAME_FLAT, 112, 0, 0, -1);
		send_frame(1'b0, FRAME_FLAT, 124, 0, 0, 123);
	endtask

	// group_start on every pixel but the first must be ignored
	task automatic test_midframe_group_start();
		send_frame(1'b0, FRAME_FLAT, 112, 0, 100, -1);
	endtask

	// Highest threshold drops even the largest sum; zero keeps a zero sum
	task automatic test_threshold_extremes();
		set_threshold('1);
		send_frame(1'b1, FRAME_FLAT, 0, 0, 0, -1);
		send_frame(1'b0, FRAME_FLAT, 255, 0, 0, -1);
		set_threshold('0);
		send_frame(1'b0, FRAME_FLAT, 0, 0, 0, -1);
		set_threshold(CFG_W'(MIN_DIFF_RESET));
	endtask

	// Random frames, mostly near-duplicates of the reference
	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_frames);
		frame_kind_e kind;
		int          pick;
		int          noise;
		int          mid_pct;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int f = 0; f < n_frames; f++) begin
			if (f % 4 == 0) begin
				case ($urandom_range(0, 3))
					0: set_threshold('0);
					1: set_threshold('1);
					2: set_threshold(CFG_W'($urandom_range(0, 4095)));
					default: set_threshold(CFG_W'($urandom_range(16, 400)));
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 70)
				kind = FRAME_NEAR;
			else if (pick < 85)
				kind = FRAME_NOISE;
			else
				kind = FRAME_FLAT;
			noise = int'(thresh_q4) / 4 + 2;
			if (noise > 255)
				noise = 255;
			noise = $urandom_range(0, noise);
			case ($urandom_range(0, 2))
				0: mid_pct = 0;
				1: mid_pct = 20;
				default: mid_pct = 50;
			endcase
			send_frame($urandom_range(0, 99) < 15, kind, $urandom_range(0, 255),
					noise, mid_pct, -1);
		end
	endtask

	// Hold the output off long enough that the input backs up
	task automatic test_backpressure();
		wait_drained();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		stall_hold = HOLDOFF_CYCLES;
		for (int f = 0; f < 3; f++)
			send_frame(1'b0, FRAME_NEAR, 0, 20, 0, -1);
	endtask

	// Drive output stall: hold-off first, else random
	initial begin
		forever begin
			@(posedge clk);
			if (stall_hold > 0) begin
				out_stall <= 1'b1;
				stall_hold--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	initial begin
		out_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (frame_results.size() == 0) begin
					$error("unexpected result transaction: %p", out_data);
					mismatches++;
				end else begin
					want = frame_results.pop_front();
					if (out_data.keep !== want.keep) begin
						$error("keep: expected %0d, got %0d", want.keep, out_data.keep);
						mismatches++;
					end
					if (out_data.first_of_group !== want.first_of_group) begin
						$error("first_of_group: expected %0d, got %0d",
								want.first_of_group, out_data.first_of_group);
						mismatches++;
					end
					if (out_data.difference_sum !== want.difference_sum) begin
						$error("difference_sum: expected %0d, got %0d",
								want.difference_sum, out_data.difference_sum);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		#30_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Test sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_after_reset();
		test_field_extremes();
		test_threshold_boundary();
		test_midframe_group_start();
		test_threshold_extremes();
		test_random_traffic(9, 74, 12);
		test_backpressure();
		test_random_traffic(74, 9, 12);
		test_random_traffic(0, 0, 12);
		wait_drained();
		if (frame_results.size() != 0) begin
			$error("%0d predicted results never arrived", frame_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
